@@ rtl/isfp_pkg.sv @@
// shared constants and types for the imu serial frame parser
`timescale 1ns / 1ps

package isfp_pkg;

   localparam int FRAME_LEN = 11;
   localparam int PAY_LEN   = FRAME_LEN - 3;
   localparam int CNT_W     = $clog2(FRAME_LEN);

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;
   localparam logic [7:0] TYPE_POS   = 8'h57;
   localparam logic [7:0] TYPE_GPS   = 8'h58;

   typedef enum logic [2:0] {
      KIND_ACCEL   = 3'd0,
      KIND_GYRO    = 3'd1,
      KIND_ANGLE   = 3'd2,
      KIND_POS     = 3'd3,
      KIND_GPS     = 3'd4,
      KIND_UNKNOWN = 3'd5
   } kind_type;

   typedef struct packed {
      logic                          frame_end;
   } status_type;

   typedef struct packed {
      logic [7:0]                    type_byte;
      logic [PAY_LEN-1:0][7:0]       pay;
      logic [7:0]                    sum;
   } frame_type;

   typedef struct packed {
      kind_type                      frame_kind;
      logic                          sum_ok;
      logic signed [15:0]            word_a;
      logic signed [15:0]            word_b;
      logic signed [15:0]            word_c;
      logic signed [15:0]            word_d;
      logic signed [31:0]            long_a;
      logic signed [31:0]            long_b;
      logic                          imu_set_ready;
      logic                          gps_set_ready;
   } result_type;

endpackage

@@ rtl/isfp_if.sv @@
// byte channel and result channel interfaces
`timescale 1ns / 1ps

interface isfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface isfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         frame_kind;
   logic               sum_ok;
   logic signed [15:0] word_a;
   logic signed [15:0] word_b;
   logic signed [15:0] word_c;
   logic signed [15:0] word_d;
   logic signed [31:0] long_a;
   logic signed [31:0] long_b;
   logic               imu_set_ready;
   logic               gps_set_ready;

   modport source (
      output valid, output frame_kind, output sum_ok,
      output word_a, output word_b, output word_c, output word_d,
      output long_a, output long_b, output imu_set_ready, output gps_set_ready,
      input ready
   );
   modport sink (
      input valid, input frame_kind, input sum_ok,
      input word_a, input word_b, input word_c, input word_d,
      input long_a, input long_b, input imu_set_ready, input gps_set_ready,
      output ready
   );
endinterface

@@ rtl/isfp_collect.sv @@
// frame byte store, byte counter and running checksum
`timescale 1ns / 1ps

module isfp_collect (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   output isfp_pkg::status_type  status,
   output isfp_pkg::frame_type   frame
);
   import isfp_pkg::*;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [7:0]              sum_ff, sum_in;
   logic [7:0]              type_ff;
   logic [PAY_LEN-1:0][7:0] pay_ff;
   logic                    last;
   logic                    drop;

   assign last = (count_ff == CNT_W'(FRAME_LEN - 1));
   assign drop = (count_ff == '0) && (rx_byte != HDR_BYTE);

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
            sum_in   = '0;
         end else if (!drop) begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // payload store, one fixed slot per byte position
   always_ff @(posedge clock) begin
      if (accept && (count_ff == CNT_W'(1))) begin
         type_ff <= rx_byte;
      end
      for (int i = 0; i < PAY_LEN; i++) begin
         if (accept && (count_ff == CNT_W'(i + 2))) begin
            pay_ff[i] <= rx_byte;
         end
      end
   end

   assign status.frame_end = last;
   assign frame.type_byte  = type_ff;
   assign frame.pay        = pay_ff;
   assign frame.sum        = sum_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FRAME_LEN - 1))
      else $error("byte count beyond frame length");

   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && drop) |=> (count_ff == '0 && sum_ff == '0))
      else $error("byte outside a frame was not dropped");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (count_ff == '0 && sum_ff == '0))
      else $error("frame state not cleared after last beat");

   a_sum_idle: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0))
      else $error("running sum nonzero with empty frame");

endmodule

@@ rtl/isfp_result.sv @@
// frame decode, checksum compare and result register
`timescale 1ns / 1ps

module isfp_result (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [7:0]            rx_byte,
   input  isfp_pkg::frame_type   frame,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  can_load,
   output isfp_pkg::result_type  result
);
   import isfp_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;
   kind_type   kind;
   logic       ok;

   always_comb begin
      unique case (frame.type_byte)
         TYPE_ACCEL: kind = KIND_ACCEL;
         TYPE_GYRO:  kind = KIND_GYRO;
         TYPE_ANGLE: kind = KIND_ANGLE;
         TYPE_POS:   kind = KIND_POS;
         TYPE_GPS:   kind = KIND_GPS;
         default:    kind = KIND_UNKNOWN;
      endcase
   end

   assign ok = (frame.sum == rx_byte);

   always_comb begin
      res_in.frame_kind    = kind;
      res_in.sum_ok        = ok;
      res_in.word_a        = signed'({frame.pay[1], frame.pay[0]});
      res_in.word_b        = signed'({frame.pay[3], frame.pay[2]});
      res_in.word_c        = signed'({frame.pay[5], frame.pay[4]});
      res_in.word_d        = signed'({frame.pay[7], frame.pay[6]});
      res_in.long_a        = signed'({frame.pay[3], frame.pay[2],
                                      frame.pay[1], frame.pay[0]});
      res_in.long_b        = signed'({frame.pay[7], frame.pay[6],
                                      frame.pay[5], frame.pay[4]});
      res_in.imu_set_ready = ok && (kind == KIND_ANGLE);
      res_in.gps_set_ready = ok && (kind == KIND_GPS);
   end

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = res_ff;

endmodule

@@ rtl/imu_serial_frame_parser.sv @@
// top level of the imu serial frame parser
// a result beat is offered in the cycle after the beat carrying the checksum byte
// throughput: one byte beat per cycle; the checksum beat waits only while a result is stalled
// bytes that cause no result are taken even while the result register is full
// reset clears the byte count, running sum and result valid; the byte store is not cleared
`timescale 1ns / 1ps

module imu_serial_frame_parser (
   input  logic      clock,
   input  logic      reset,
   isfp_req_if.sink  req_ch,
   isfp_rsp_if.source rsp_ch
);
   import isfp_pkg::*;

   status_type status;
   frame_type  frame;
   result_type result;
   logic       accept;
   logic       can_load;
   logic       rsp_valid;

   assign req_ch.ready = !status.frame_end || can_load;
   assign accept       = req_ch.valid && req_ch.ready;

   isfp_collect u_collect (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_ch.rx_byte),
      .status  (status),
      .frame   (frame)
   );

   isfp_result u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && status.frame_end),
      .rx_byte   (req_ch.rx_byte),
      .frame     (frame),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .result    (result)
   );

   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.frame_kind    = result.frame_kind;
   assign rsp_ch.sum_ok        = result.sum_ok;
   assign rsp_ch.word_a        = result.word_a;
   assign rsp_ch.word_b        = result.word_b;
   assign rsp_ch.word_c        = result.word_c;
   assign rsp_ch.word_d        = result.word_d;
   assign rsp_ch.long_a        = result.long_a;
   assign rsp_ch.long_b        = result.long_b;
   assign rsp_ch.imu_set_ready = result.imu_set_ready;
   assign rsp_ch.gps_set_ready = result.gps_set_ready;

endmodule

@@ dv/tb_imu_serial_frame_parser.sv @@
// testbench for the imu serial frame parser: byte streams checked against a local frame decoder
`timescale 1ns / 1ps

module tb_imu_serial_frame_parser;
   import isfp_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_BEATS = 1100;
   localparam int DRAIN_CYCLES = 20;

   class frame_scoreboard;
      logic [7:0]  held_bytes [FRAME_LEN];
      int unsigned held_count;
      logic [7:0]  held_sum;
      result_type  pending [$];
      int unsigned errors;

      function new();
         held_count = 0;
         held_sum   = 8'h00;
         errors     = 0;
      endfunction

      function kind_type decode_kind(logic [7:0] type_byte);
         case (type_byte)
            TYPE_ACCEL: return KIND_ACCEL;
            TYPE_GYRO:  return KIND_GYRO;
            TYPE_ANGLE: return KIND_ANGLE;
            TYPE_POS:   return KIND_POS;
            TYPE_GPS:   return KIND_GPS;
            default:    return KIND_UNKNOWN;
         endcase
      endfunction

      // byte beat taken by the block
      function void note_byte(logic [7:0] b);
         result_type r;
         if (held_count == 0 && b != HDR_BYTE) return;
         held_bytes[held_count] = b;
         if (held_count < FRAME_LEN - 1) begin
            held_sum   = held_sum + b;
            held_count = held_count + 1;
            return;
         end
         r.frame_kind    = decode_kind(held_bytes[1]);
         r.sum_ok        = (held_sum == b);
         r.word_a        = {held_bytes[3], held_bytes[2]};
         r.word_b        = {held_bytes[5], held_bytes[4]};
         r.word_c        = {held_bytes[7], held_bytes[6]};
         r.word_d        = {held_bytes[9], held_bytes[8]};
         r.long_a        = {held_bytes[5], held_bytes[4], held_bytes[3], held_bytes[2]};
         r.long_b        = {held_bytes[9], held_bytes[8], held_bytes[7], held_bytes[6]};
         r.imu_set_ready = r.sum_ok && (r.frame_kind == KIND_ANGLE);
         r.gps_set_ready = r.sum_ok && (r.frame_kind == KIND_GPS);
         pending = {pending, r};
         held_count = 0;
         held_sum   = 8'h00;
      endfunction

      function void field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors = errors + 1;
            if (errors <= 10)
               $display("%s: expected %h, got %h", name, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            errors = errors + 1;
            if (errors <= 10)
               $display("result beat with nothing pending: kind %0d", got.frame_kind);
            return;
         end
         want = pending.pop_front();
         field("frame_kind", want.frame_kind, got.frame_kind);
         field("sum_ok", want.sum_ok, got.sum_ok);
         field("word_a", want.word_a, got.word_a);
         field("word_b", want.word_b, got.word_b);
         field("word_c", want.word_c, got.word_c);
         field("word_d", want.word_d, got.word_d);
         field("long_a", want.long_a, got.long_a);
         field("long_b", want.long_b, got.long_b);
         field("imu_set_ready", want.imu_set_ready, got.imu_set_ready);
         field("gps_set_ready", want.gps_set_ready, got.gps_set_ready);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   isfp_req_if req_ch ();
   isfp_rsp_if rsp_ch ();

   imu_serial_frame_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   frame_scoreboard sb;
   logic [7:0]      frame_buf [FRAME_LEN];
   logic [7:0]      type_codes [5] = '{TYPE_ACCEL, TYPE_GYRO, TYPE_ANGLE, TYPE_POS, TYPE_GPS};
   int              burst_left = 0;
   int              frame_beats = 0;
   int              idle_cycles = 0;

   always #5 clock = ~clock;

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_ch.valid   = 1'b1;
      req_ch.rx_byte = b;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_byte(b);
      burst_left = burst_left - 1;
      @(negedge clock);
   endtask

   // sends the first keep bytes of frame_buf, checksum filled in when good_sum
   task automatic send_frame(input bit good_sum, input int keep);
      logic [7:0] sum;
      sum = 8'h00;
      for (int i = 0; i < FRAME_LEN - 1; i++)
         sum = sum + frame_buf[i];
      frame_buf[FRAME_LEN-1] = good_sum ? sum : sum + 8'($urandom_range(1, 255));
      for (int i = 0; i < keep; i++) begin
         send_byte(frame_buf[i]);
         frame_beats = frame_beats + 1;
      end
   endtask

   function automatic logic [7:0] pay_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return HDR_BYTE;
         3:       return 8'h80;
         4:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   // receiver stalls: always ready, coin toss, or long stall runs
   initial begin : rsp_stall_pattern
      int  mode;
      int  mode_left;
      int  run_left;
      bit  stalled;
      mode_left = 0;
      run_left  = 0;
      stalled   = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
         end
         mode_left = mode_left - 1;
         case (mode)
            0: rsp_ch.ready = 1'b1;
            1: rsp_ch.ready = 1'($urandom_range(0, 1));
            default: begin
               if (run_left == 0) begin
                  stalled  = !stalled;
                  run_left = stalled ? $urandom_range(1, 25) : $urandom_range(1, 6);
               end
               run_left = run_left - 1;
               rsp_ch.ready = !stalled;
            end
         endcase
      end
   end

   always @(posedge clock) begin : rsp_monitor
      result_type got;
      got.frame_kind    = kind_type'(rsp_ch.frame_kind);
      got.sum_ok        = rsp_ch.sum_ok;
      got.word_a        = rsp_ch.word_a;
      got.word_b        = rsp_ch.word_b;
      got.word_c        = rsp_ch.word_c;
      got.word_d        = rsp_ch.word_d;
      got.long_a        = rsp_ch.long_a;
      got.long_b        = rsp_ch.long_b;
      got.imu_set_ready = rsp_ch.imu_set_ready;
      got.gps_set_ready = rsp_ch.gps_set_ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(got);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("imu_serial_frame_parser: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int keep;
      int pick;
      sb = new();
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // bytes outside a frame are dropped
      send_byte(8'h00);
      send_byte(8'hFF);
      // good angle frame, header byte and extremes inside the payload
      frame_buf = '{HDR_BYTE, TYPE_ANGLE, 8'h00, 8'hFF, HDR_BYTE, 8'h80,
                    8'h7F, 8'h01, 8'hFE, HDR_BYTE, 8'h00};
      send_frame(1'b1, FRAME_LEN);
      // gps frame with a bad checksum
      frame_buf = '{HDR_BYTE, TYPE_GPS, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'h00, 8'h80, 8'h00};
      send_frame(1'b0, FRAME_LEN);

      frame_beats = 0;
      while (frame_beats < RANDOM_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_byte(8'($urandom));
         end else begin
            frame_buf[0] = HDR_BYTE;
            frame_buf[1] = ($urandom_range(0, 5) == 5) ? 8'($urandom)
                                                       : type_codes[$urandom_range(0, 4)];
            for (int i = 2; i < FRAME_LEN - 1; i++)
               frame_buf[i] = pay_byte();
            // occasionally a frame is cut short and the next one runs into it
            keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
            send_frame($urandom_range(0, 4) != 0, keep);
         end
      end
      req_ch.valid = 1'b0;

      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("imu_serial_frame_parser: match");
      else
         $display("imu_serial_frame_parser: mismatch");
      $finish;
   end

endmodule

@@ imu_serial_frame_parser.f @@
rtl/isfp_pkg.sv
rtl/isfp_if.sv
rtl/isfp_collect.sv
rtl/isfp_result.sv
rtl/imu_serial_frame_parser.sv
dv/tb_imu_serial_frame_parser.sv
